@@ design/assert_macros.svh @@
// Assertion macros used by the min/max stack RTL.
// No dependencies; assertions compile out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_NORST(label, clk, prop, msg)
`endif
`endif

@@ design/mms_pkg.sv @@
// Types and constants for the min/max stack.
// No dependencies; imported by every module of the block.
package mms_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int WW       = 32;
    localparam int PKW      = 6;
    localparam int DEPTHW   = 7;
    localparam int CMPW     = (CW > PKW) ? CW + 1 : PKW + 1;

    typedef logic signed [WW-1:0] t_word;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    // top entry with its running max/min
    typedef struct packed {
        t_word val;
        t_word mx;
        t_word mn;
    } t_top;

    // per-transaction info handed from the stack to the result stage
    typedef struct packed {
        t_status         status;
        logic [CW-1:0]   count;
        logic            peek_valid;
        logic            peek_top;
    } t_meta;

endpackage

@@ design/mms_stack.sv @@
// Stack state: depth counter, top-of-stack registers and entry memories.
// Depends on mms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mms_stack
    import mms_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [1:0]     i_op,
    input  t_word          i_push_value,
    input  logic [PKW-1:0] i_peek_depth,
    output t_meta          o_meta,
    output t_top           o_top,
    output t_word          o_peek_rd
);

    t_word entries_mem [CAPACITY];
    t_word max_mem     [CAPACITY];
    t_word min_mem     [CAPACITY];

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_top          r_top;
    t_top          n_top;
    logic          r_from_mem;
    logic          n_from_mem;
    t_top          r_rd_top;
    t_word         r_rd_peek;

    t_top          e_top;
    t_top          push_top;
    t_op           op;
    t_status       status;
    logic          full;
    logic          empty;
    logic          do_push;
    logic          do_pop;
    logic [AW-1:0] pop_addr;
    logic [CMPW-1:0] pk_ext;
    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] peek_idx;
    logic [AW-1:0] peek_addr;

    // top after a pop is taken from the read register, then copied into r_top
    assign e_top = r_from_mem ? r_rd_top : r_top;

    always_comb begin
        op       = t_op'(i_op);
        full     = (r_count == CW'(CAPACITY));
        empty    = (r_count == '0);
        status   = ST_OK;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        n_count  = r_count;
        unique case (op)
            OP_NONE: begin
                n_count = r_count;
            end
            OP_PUSH: begin
                if (full) begin
                    status = ST_PUSH_FULL;
                end else begin
                    do_push = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP: begin
                if (empty) begin
                    status = ST_POP_EMPTY;
                end else begin
                    do_pop  = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase

        push_top.val = i_push_value;
        push_top.mx  = (!empty && (i_push_value < e_top.mx)) ? e_top.mx : i_push_value;
        push_top.mn  = (!empty && (e_top.mn < i_push_value)) ? e_top.mn : i_push_value;

        pop_addr  = AW'(r_count - CW'(2));
        pk_ext    = CMPW'(i_peek_depth);
        cnt_ext   = CMPW'(n_count);
        peek_idx  = cnt_ext - CMPW'(1) - pk_ext;
        peek_addr = peek_idx[AW-1:0];

        o_meta.status     = status;
        o_meta.count      = n_count;
        o_meta.peek_valid = (pk_ext < cnt_ext);
        o_meta.peek_top   = (i_peek_depth == '0);

        n_top      = e_top;
        n_from_mem = 1'b0;
        if (i_accept && do_push) begin
            n_top = push_top;
        end else if (i_accept && do_pop) begin
            n_from_mem = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_from_mem <= 1'b0;
        end else begin
            if (i_accept) begin
                r_count <= n_count;
            end
            r_from_mem <= n_from_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && do_push) begin
            entries_mem[r_count[AW-1:0]] <= push_top.val;
            max_mem[r_count[AW-1:0]]     <= push_top.mx;
            min_mem[r_count[AW-1:0]]     <= push_top.mn;
        end
    end

    // read data held while the result stage stalls
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_top.val <= entries_mem[pop_addr];
            r_rd_top.mx  <= max_mem[pop_addr];
            r_rd_top.mn  <= min_mem[pop_addr];
            r_rd_peek    <= entries_mem[peek_addr];
        end
    end

    assign o_top     = e_top;
    assign o_peek_rd = r_rd_peek;

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "depth above capacity")
    `ASSERT_CLK(a_count_hold, i_clk, i_rst_n, !i_accept |=> $stable(r_count), "depth moved while idle")
    `ASSERT_CLK(a_push_inc, i_clk, i_rst_n, (i_accept && do_push) |=> (r_count == $past(r_count) + CW'(1)), "push did not grow stack")
    `ASSERT_CLK(a_mem_top_once, i_clk, i_rst_n, !i_accept |=> !r_from_mem, "stale pop read selected")

endmodule

@@ design/mms_result.sv @@
// Result stage: transaction register, output muxing and output register.
// Depends on mms_pkg.
module mms_result
    import mms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_meta             i_meta,
    input  t_top              i_top,
    input  t_word             i_peek_rd,
    input  logic              i_ready,
    output logic              o_take,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output t_word             o_top_value,
    output logic [DEPTHW-1:0] o_depth,
    output t_word             o_max_value,
    output t_word             o_min_value,
    output t_word             o_peek_value,
    output logic              o_peek_valid,
    output logic              o_is_empty,
    output logic              o_is_full
);

    logic  r_s1_valid;
    t_meta r_s1;
    logic  r_out_valid;
    logic  adv;
    logic  nonempty;

    logic [1:0]        r_status;
    t_word             r_top_value;
    logic [DEPTHW-1:0] r_depth;
    t_word             r_max_value;
    t_word             r_min_value;
    t_word             r_peek_value;
    logic              r_peek_valid;
    logic              r_is_empty;
    logic              r_is_full;

    assign adv      = r_s1_valid && (!r_out_valid || i_ready);
    assign o_take   = !r_s1_valid || adv;
    assign nonempty = (r_s1.count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status     <= 2'(r_s1.status);
            r_top_value  <= nonempty ? i_top.val : '0;
            r_depth      <= DEPTHW'(r_s1.count);
            r_max_value  <= nonempty ? i_top.mx : '0;
            r_min_value  <= nonempty ? i_top.mn : '0;
            r_peek_value <= !r_s1.peek_valid ? '0 :
                            (r_s1.peek_top ? i_top.val : i_peek_rd);
            r_peek_valid <= r_s1.peek_valid;
            r_is_empty   <= !nonempty;
            r_is_full    <= (r_s1.count == CW'(CAPACITY));
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_top_value  = r_top_value;
    assign o_depth      = r_depth;
    assign o_max_value  = r_max_value;
    assign o_min_value  = r_min_value;
    assign o_peek_value = r_peek_value;
    assign o_peek_valid = r_peek_valid;
    assign o_is_empty   = r_is_empty;
    assign o_is_full    = r_is_full;

endmodule

@@ design/min_max_stack_core.sv @@
// Bounded stack of signed 32-bit words with running max/min per entry.
// One transaction per cycle is taken when o_ready is high: the operation updates
// the depth and entry memories at the edge that accepts it; its result moves
// from the transaction register to the output register, raising o_valid, when
// that is free or drained. The entry memory has two read ports (top after a pop,
// and the peek entry), which lets every operation finish in a single pass.
// While a result waits at the output, one more transaction is taken into the
// transaction register; o_ready stays low until the waiting result is taken.
// Depends on mms_pkg, mms_stack and mms_result.
module min_max_stack_core
    import mms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_op,
    input  t_word             i_push_value,
    input  logic [PKW-1:0]    i_peek_depth,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output t_word             o_top_value,
    output logic [DEPTHW-1:0] o_depth,
    output t_word             o_max_value,
    output t_word             o_min_value,
    output t_word             o_peek_value,
    output logic              o_peek_valid,
    output logic              o_is_empty,
    output logic              o_is_full
);

    logic  take;
    logic  accept;
    t_meta meta;
    t_top  top;
    t_word peek_rd;

    assign accept  = i_valid && take;
    assign o_ready = take;

    mms_stack u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (i_op),
        .i_push_value (i_push_value),
        .i_peek_depth (i_peek_depth),
        .o_meta       (meta),
        .o_top        (top),
        .o_peek_rd    (peek_rd)
    );

    mms_result u_result (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_meta       (meta),
        .i_top        (top),
        .i_peek_rd    (peek_rd),
        .i_ready      (i_ready),
        .o_take       (take),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_top_value  (o_top_value),
        .o_depth      (o_depth),
        .o_max_value  (o_max_value),
        .o_min_value  (o_min_value),
        .o_peek_value (o_peek_value),
        .o_peek_valid (o_peek_valid),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

endmodule
